@@ rtl/pgf_pkg.sv @@
// Shared widths, codes and stage types for the pairwise gravity force pipeline.
package pgf_pkg;

   // Field widths.
   localparam int CoordW = 32;
   localparam int MassW  = 32;
   localparam int CfgW   = 32;
   localparam int ForceW = 64;
   localparam int DiffW  = CoordW + 1;
   localparam int DsqW   = 66;
   localparam int RootW  = 49;
   localparam int RadW   = 98;
   localparam int BaseW  = 96;
   localparam int DenW   = 115;
   localparam int NumW   = 129;

   // Number of root and quotient steps.
   localparam int SqSteps  = RootW;
   localparam int DivSteps = ForceW;

   // Packed port widths.
   localparam int ReqDataW = 6 * CoordW;
   localparam int RspDataW = 2 * ForceW;

   // Register indexes of the control port.
   typedef enum logic [0:0] {
      CSR_GRAVITY   = 1'b0,
      CSR_SOFTENING = 1'b1
   } csr_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_SAT  = 2'd1,
      STAT_ZERO = 2'd2
   } status_type;

   // Values that travel beside the square root stages.
   typedef struct packed {
      logic             dz;
      logic             sx;
      logic             sy;
      logic [DiffW-1:0] ux;
      logic [DiffW-1:0] uy;
      logic [DsqW-1:0]  dsq;
      logic [BaseW-1:0] base;
   } sq_side_type;

   // Values that travel beside the divider stages.
   typedef struct packed {
      logic            dz;
      logic            sx;
      logic            sy;
      logic            ovx;
      logic            ovy;
      logic [DenW-1:0] den;
   } dv_side_type;

endpackage

@@ rtl/pairwise_gravity_force.sv @@
// Pairwise softened gravity force, fully pipelined, one body pair per cycle unless stalled.
//
//  Channel  Direction  Contents
//  req_*    in         body_a_x, body_a_y, body_a_mass, body_b_x, body_b_y, body_b_mass
//  rsp_*    out        force_x, force_y in tdata; status in tuser
//  csr_*    in         gravity_constant (index 0), softening_length (index 1)
//
// A new word is taken every cycle while the output buffer is not full.
// The pipeline holds 49 square root steps and 64 quotient steps,
// one step per stage. Reset is synchronous, clears the valid bits and loads
// the register defaults.
// A two-word output buffer lets the pipeline keep taking words while one result
// waits; the pipeline holds only when both buffer entries are full.
module pairwise_gravity_force (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0 up: body_a_x, body_a_y, body_a_mass, body_b_x, body_b_y, body_b_mass.
   input  logic [pgf_pkg::ReqDataW-1:0]    req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0 up: force_x, force_y.
   output logic [pgf_pkg::RspDataW-1:0]    rsp_tdata,
   // Fields from bit 0 up: status.
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_we,
   input  logic [0:0]                      csr_index,
   input  logic [pgf_pkg::CfgW-1:0]        csr_wdata
);
   import pgf_pkg::*;

   // Control registers.
   logic [CfgW-1:0] grav_ff, soft_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= CfgW'(65536);
         soft_ff <= CfgW'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GRAVITY:   grav_ff <= csr_wdata;
            CSR_SOFTENING: soft_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // Pipeline advance; held only when the output buffer is full.
   logic [1:0] cnt_ff;
   logic       en;
   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;

   // Input field unpacking.
   logic [CoordW-1:0] a_x, a_y, b_x, b_y;
   logic [MassW-1:0]  a_m, b_m;
   assign a_x = req_tdata[0*CoordW +: CoordW];
   assign a_y = req_tdata[1*CoordW +: CoordW];
   assign a_m = req_tdata[2*CoordW +: CoordW];
   assign b_x = req_tdata[3*CoordW +: CoordW];
   assign b_y = req_tdata[4*CoordW +: CoordW];
   assign b_m = req_tdata[5*CoordW +: CoordW];

   // Stage 1: differences, G times mass A, softening squared.
   logic             v1_ff;
   logic [DiffW-1:0] dx_ff, dy_ff;
   logic [MassW-1:0] mb_ff;
   logic [63:0]      gm_ff, eps2_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff   <= {b_x[CoordW-1], b_x} - {a_x[CoordW-1], a_x};
         dy_ff   <= {b_y[CoordW-1], b_y} - {a_y[CoordW-1], a_y};
         mb_ff   <= b_m;
         gm_ff   <= 64'(grav_ff) * 64'(a_m);
         eps2_ff <= 64'(soft_ff) * 64'(soft_ff);
      end
   end

   // Stage 2: magnitudes and their squares, partial products of G * mA * mB.
   logic             v2_ff, sx2_ff, sy2_ff;
   logic [DiffW-1:0] ux2_ff, uy2_ff;
   logic [64:0]      uxsq_ff, uysq_ff;
   logic [63:0]      eps2b_ff, pglo_ff, pghi_ff;
   logic [DiffW-1:0] ux_c, uy_c;

   assign ux_c = dx_ff[DiffW-1] ? (DiffW'(0) - dx_ff) : dx_ff;
   assign uy_c = dy_ff[DiffW-1] ? (DiffW'(0) - dy_ff) : dy_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx2_ff   <= dx_ff[DiffW-1];
         sy2_ff   <= dy_ff[DiffW-1];
         ux2_ff   <= ux_c;
         uy2_ff   <= uy_c;
         uxsq_ff  <= 65'(66'(ux_c) * 66'(ux_c));
         uysq_ff  <= 65'(66'(uy_c) * 66'(uy_c));
         eps2b_ff <= eps2_ff;
         pglo_ff  <= 64'(gm_ff[31:0]) * 64'(mb_ff);
         pghi_ff  <= 64'(gm_ff[63:32]) * 64'(mb_ff);
      end
   end

   // Stage 3: squared distance and the product base, enter the root stages.
   logic [DsqW-1:0]  dsq_c;
   logic [BaseW-1:0] base_c;
   assign dsq_c  = DsqW'(uxsq_ff) + DsqW'(uysq_ff) + DsqW'(eps2b_ff);
   assign base_c = {pghi_ff, 32'd0} + BaseW'(pglo_ff);

   // Square root stages: index 0 is the entry register.
   logic              sqv_ff   [0:SqSteps];
   logic [RadW-1:0]   sqrem_ff [0:SqSteps];
   logic [RootW-1:0]  sqrt_ff  [0:SqSteps];
   sq_side_type       sqsd_ff  [0:SqSteps];

   always_ff @(posedge clock) begin
      if (reset) sqv_ff[0] <= 1'b0;
      else if (en) sqv_ff[0] <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqrem_ff[0]     <= {dsq_c, 32'd0};
         sqrt_ff[0]      <= '0;
         sqsd_ff[0].dz   <= (dsq_c == '0);
         sqsd_ff[0].sx   <= sx2_ff;
         sqsd_ff[0].sy   <= sy2_ff;
         sqsd_ff[0].ux   <= ux2_ff;
         sqsd_ff[0].uy   <= uy2_ff;
         sqsd_ff[0].dsq  <= dsq_c;
         sqsd_ff[0].base <= base_c;
      end
   end

   // One root bit per stage, most significant first.
   for (genvar i = 0; i < SqSteps; i++) begin : g_sq
      localparam int B = SqSteps - 1 - i;
      logic [RadW-1:0] trial;
      logic            take;

      assign trial = (RadW'(sqrt_ff[i]) << (B + 1)) | (RadW'(1) << (2 * B));
      assign take  = (sqrem_ff[i] >= trial);

      always_ff @(posedge clock) begin
         if (reset) sqv_ff[i+1] <= 1'b0;
         else if (en) sqv_ff[i+1] <= sqv_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sqrem_ff[i+1] <= take ? (sqrem_ff[i] - trial) : sqrem_ff[i];
            sqrt_ff[i+1]  <= take ? (sqrt_ff[i] | (RootW'(1) << B)) : sqrt_ff[i];
            sqsd_ff[i+1]  <= sqsd_ff[i];
         end
      end
   end

   // Multiply stage 1: partial products of the denominator and numerators.
   sq_side_type    sqo;
   logic [RootW-1:0] root;
   assign sqo  = sqsd_ff[SqSteps];
   assign root = sqrt_ff[SqSteps];

   logic        m1v_ff, m1dz_ff, m1sx_ff, m1sy_ff;
   logic [64:0] pd00_ff, pd10_ff;
   logic [49:0] pd01_ff, pd11_ff;
   logic [64:0] px0_ff, px1_ff, px2_ff, py0_ff, py1_ff, py2_ff;

   always_ff @(posedge clock) begin
      if (reset) m1v_ff <= 1'b0;
      else if (en) m1v_ff <= sqv_ff[SqSteps];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1dz_ff <= sqo.dz;
         m1sx_ff <= sqo.sx;
         m1sy_ff <= sqo.sy;
         pd00_ff <= 65'(sqo.dsq[32:0]) * 65'(root[31:0]);
         pd01_ff <= 50'(sqo.dsq[32:0]) * 50'(root[48:32]);
         pd10_ff <= 65'(sqo.dsq[65:33]) * 65'(root[31:0]);
         pd11_ff <= 50'(sqo.dsq[65:33]) * 50'(root[48:32]);
         px0_ff  <= 65'(sqo.base[31:0])  * 65'(sqo.ux);
         px1_ff  <= 65'(sqo.base[63:32]) * 65'(sqo.ux);
         px2_ff  <= 65'(sqo.base[95:64]) * 65'(sqo.ux);
         py0_ff  <= 65'(sqo.base[31:0])  * 65'(sqo.uy);
         py1_ff  <= 65'(sqo.base[63:32]) * 65'(sqo.uy);
         py2_ff  <= 65'(sqo.base[95:64]) * 65'(sqo.uy);
      end
   end

   // Multiply stage 2: sum the partial products.
   logic            m2v_ff, m2dz_ff, m2sx_ff, m2sy_ff;
   logic [DenW-1:0] den_ff;
   logic [NumW-1:0] numx_ff, numy_ff;

   always_ff @(posedge clock) begin
      if (reset) m2v_ff <= 1'b0;
      else if (en) m2v_ff <= m1v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2dz_ff <= m1dz_ff;
         m2sx_ff <= m1sx_ff;
         m2sy_ff <= m1sy_ff;
         den_ff  <= DenW'(pd00_ff) + (DenW'(pd01_ff) << 32) + (DenW'(pd10_ff) << 33)
                  + (DenW'(pd11_ff) << 65);
         numx_ff <= NumW'(px0_ff) + (NumW'(px1_ff) << 32) + (NumW'(px2_ff) << 64);
         numy_ff <= NumW'(py0_ff) + (NumW'(py1_ff) << 32) + (NumW'(py2_ff) << 64);
      end
   end

   // Divider entry: the numerator is scaled by 2^32 for the Q32.32 result, so the
   // upper part is numerator bits 128..32 and 32 zero bits follow the low bits.
   // Overflow when that upper part reaches the denominator.
   logic        ovx_c, ovy_c;
   assign ovx_c = (DenW'(numx_ff[NumW-1:32]) >= den_ff);
   assign ovy_c = (DenW'(numy_ff[NumW-1:32]) >= den_ff);

   logic            dvv_ff  [0:DivSteps];
   dv_side_type     dvsd_ff [0:DivSteps];
   logic [DenW-1:0] remx_ff [0:DivSteps];
   logic [DenW-1:0] remy_ff [0:DivSteps];
   logic [63:0]     qx_ff   [0:DivSteps];
   logic [63:0]     qy_ff   [0:DivSteps];
   logic [63:0]     nlx_ff  [0:DivSteps];
   logic [63:0]     nly_ff  [0:DivSteps];

   always_ff @(posedge clock) begin
      if (reset) dvv_ff[0] <= 1'b0;
      else if (en) dvv_ff[0] <= m2v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dvsd_ff[0].dz  <= m2dz_ff;
         dvsd_ff[0].sx  <= m2sx_ff;
         dvsd_ff[0].sy  <= m2sy_ff;
         dvsd_ff[0].ovx <= ovx_c;
         dvsd_ff[0].ovy <= ovy_c;
         dvsd_ff[0].den <= den_ff;
         remx_ff[0]     <= ovx_c ? '0 : DenW'(numx_ff[NumW-1:32]);
         remy_ff[0]     <= ovy_c ? '0 : DenW'(numy_ff[NumW-1:32]);
         qx_ff[0]       <= '0;
         qy_ff[0]       <= '0;
         nlx_ff[0]      <= {numx_ff[31:0], 32'd0};
         nly_ff[0]      <= {numy_ff[31:0], 32'd0};
      end
   end

   // One quotient bit per stage for each component.
   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      logic [DenW:0] rx2, ry2, dext;
      logic          gex, gey;

      assign dext = {1'b0, dvsd_ff[k].den};
      assign rx2  = {remx_ff[k], nlx_ff[k][63]};
      assign ry2  = {remy_ff[k], nly_ff[k][63]};
      assign gex  = (rx2 >= dext);
      assign gey  = (ry2 >= dext);

      always_ff @(posedge clock) begin
         if (reset) dvv_ff[k+1] <= 1'b0;
         else if (en) dvv_ff[k+1] <= dvv_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dvsd_ff[k+1] <= dvsd_ff[k];
            remx_ff[k+1] <= gex ? DenW'(rx2 - dext) : rx2[DenW-1:0];
            remy_ff[k+1] <= gey ? DenW'(ry2 - dext) : ry2[DenW-1:0];
            qx_ff[k+1]   <= {qx_ff[k][62:0], gex};
            qy_ff[k+1]   <= {qy_ff[k][62:0], gey};
            nlx_ff[k+1]  <= {nlx_ff[k][62:0], 1'b0};
            nly_ff[k+1]  <= {nly_ff[k][62:0], 1'b0};
         end
      end
   end

   // Saturation, sign and the zero distance case.
   dv_side_type       dvo;
   logic [63:0]       limx, limy, magx, magy;
   logic              satx, saty;
   logic [ForceW-1:0] fx_c, fy_c;
   status_type        st_c;

   assign dvo = dvsd_ff[DivSteps];

   always_comb begin
      limx = dvo.sx ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      limy = dvo.sy ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      satx = dvo.ovx || (qx_ff[DivSteps] > limx);
      saty = dvo.ovy || (qy_ff[DivSteps] > limy);
      magx = satx ? limx : qx_ff[DivSteps];
      magy = saty ? limy : qy_ff[DivSteps];
      if (dvo.dz) begin
         fx_c = '0;
         fy_c = '0;
         st_c = STAT_ZERO;
      end else begin
         fx_c = dvo.sx ? (64'd0 - magx) : magx;
         fy_c = dvo.sy ? (64'd0 - magy) : magy;
         st_c = (satx || saty) ? STAT_SAT : STAT_OK;
      end
   end

   // Two-word output buffer; entry 0 is the head.
   logic [RspDataW-1:0] ob0_ff, ob1_ff;
   logic [1:0]          os0_ff, os1_ff;
   logic                push, pop;

   assign push = en && dvv_ff[DivSteps];
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push && (cnt_ff == 2'd0 || (pop && cnt_ff == 2'd1))) begin
         ob0_ff <= {fy_c, fx_c};
         os0_ff <= st_c;
      end else if (pop) begin
         ob0_ff <= ob1_ff;
         os0_ff <= os1_ff;
      end
      if (push && !pop && cnt_ff == 2'd1) begin
         ob1_ff <= {fy_c, fx_c};
         os1_ff <= st_c;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = ob0_ff;
   assign rsp_tuser  = os0_ff;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the pairwise gravity force pipeline.
module tb;
   import pgf_pkg::*;

   typedef struct {
      logic [CoordW-1:0] ax, ay;
      logic [MassW-1:0]  am;
      logic [CoordW-1:0] bx, by;
      logic [MassW-1:0]  bm;
   } pair_type;

   typedef struct {
      logic [ForceW-1:0] fx, fy;
      status_type        st;
   } force_type;

   // One directed row: the setting it runs under, the pair, and an optional typed answer.
   typedef struct {
      logic [CfgW-1:0] g, eps;
      pair_type        p;
      bit              typed;
      force_type       want;
   } row_type;

   localparam int Latency = 121;
   localparam int NumRandom = 550;

   logic                clock;
   logic                reset;
   logic                req_tvalid, req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid, rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_we;
   logic [0:0]          csr_index;
   logic [CfgW-1:0]     csr_wdata;

   logic [CfgW-1:0] grav_now, soft_now;
   force_type       force_queue[$];
   int              fail_count;
   int              pairs_taken;

   pairwise_gravity_force u_top (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 900000);
      $display("[pairwise_gravity_force] ERROR");
      $finish;
   end

   // Integer square root, floor, of a value below 2^98.
   function automatic logic [RootW-1:0] root_floor(logic [255:0] x);
      logic [RootW-1:0] s;
      logic [RootW-1:0] t;
      s = '0;
      for (int b = RootW - 1; b >= 0; b--) begin
         t = s | (49'd1 << b);
         if ({207'd0, t} * {207'd0, t} <= x) s = t;
      end
      return s;
   endfunction

   // One force component: scaled quotient, truncated, saturated, then signed.
   function automatic logic [ForceW-1:0] axis_force(logic [DiffW-1:0] d, logic [255:0] base,
                                                     logic [255:0] den, inout bit sat);
      logic             neg;
      logic [DiffW-1:0] mag;
      logic [255:0]     q;
      logic [255:0]     limit;
      logic [63:0]      m;
      neg = d[DiffW-1];
      mag = neg ? (~d + 1'b1) : d;
      q = (base * {223'd0, mag}) / den;
      limit = neg ? 256'h8000_0000_0000_0000 : 256'h7fff_ffff_ffff_ffff;
      if (q > limit) begin
         sat = 1'b1;
         m = limit[63:0];
      end else begin
         m = q[63:0];
      end
      return neg ? (64'd0 - m) : m;
   endfunction

   function automatic force_type gravity_force(pair_type p);
      force_type        r;
      logic [DiffW-1:0] dx, dy, ux, uy;
      logic [255:0]     dsq, base, den;
      bit               sat;
      sat = 1'b0;
      dx = {p.bx[31], p.bx} - {p.ax[31], p.ax};
      dy = {p.by[31], p.by} - {p.ay[31], p.ay};
      ux = dx[32] ? (~dx + 1'b1) : dx;
      uy = dy[32] ? (~dy + 1'b1) : dy;
      dsq = {223'd0, ux} * {223'd0, ux} + {223'd0, uy} * {223'd0, uy}
            + {224'd0, soft_now} * {224'd0, soft_now};
      if (dsq == 0) begin
         r.fx = '0;
         r.fy = '0;
         r.st = STAT_ZERO;
         return r;
      end
      den = dsq * {207'd0, root_floor(dsq << 32)};
      base = (({224'd0, grav_now} * {224'd0, p.am}) * {224'd0, p.bm}) << 32;
      r.fx = axis_force(dx, base, den, sat);
      r.fy = axis_force(dy, base, den, sat);
      r.st = sat ? STAT_SAT : STAT_OK;
      return r;
   endfunction

   // Register write, only issued once the pipeline has drained.
   task automatic write_csr(csr_index_type idx, logic [CfgW-1:0] val);
      wait (force_queue.size() == 0);
      repeat (Latency + 4) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_GRAVITY) grav_now = val;
      else soft_now = val;
   endtask

   task automatic set_config(logic [CfgW-1:0] g, logic [CfgW-1:0] eps);
      if (g != grav_now) write_csr(CSR_GRAVITY, g);
      if (eps != soft_now) write_csr(CSR_SOFTENING, eps);
   endtask

   // Offer one word at the falling edge and hold it until it is taken.
   task automatic send_pair(pair_type p, bit typed, force_type want);
      int gap;
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
      repeat (gap) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {p.bm, p.by, p.bx, p.am, p.ay, p.ax};
      do @(posedge clock); while (!req_tready);
      force_queue.push_back(typed ? want : gravity_force(p));
      pairs_taken++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   function automatic pair_type random_pair();
      pair_type p;
      int       mode;
      mode = $urandom_range(0, 3);
      p.ax = $urandom;
      p.ay = $urandom;
      p.am = $urandom;
      p.bm = $urandom;
      if (mode == 0) begin
         p.bx = $urandom;
         p.by = $urandom;
      end else begin
         // Nearby bodies, with modest masses in the two nearest modes, give forces in range.
         p.bx = p.ax + $urandom_range(0, 1 << (4 * mode + 8)) - (1 << (4 * mode + 7));
         p.by = p.ay + $urandom_range(0, 1 << (4 * mode + 8)) - (1 << (4 * mode + 7));
         if (mode < 3) begin
            p.am = $urandom_range(0, 32'h00ff_ffff);
            p.bm = $urandom_range(0, 32'h00ff_ffff);
         end
      end
      return p;
   endfunction

   // Receiver: random stalls, with one long hold-off once traffic is flowing.
   initial begin
      bit held;
      int gap;
      held = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && pairs_taken >= 150) begin
            held = 1'b1;
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
         end
         gap = ($urandom_range(0, 9) < 6) ? 0 :
               ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
         rsp_tready = (gap == 0);
         repeat (gap) @(negedge clock);
      end
   end

   // Result checker: every word taken is compared with the oldest expectation.
   always @(posedge clock) begin
      force_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (force_queue.size() == 0) begin
            $display("%0t: unexpected result word fx=%h fy=%h st=%0d", $time,
                     rsp_tdata[63:0], rsp_tdata[127:64], rsp_tuser);
            fail_count++;
         end else begin
            want = force_queue.pop_front();
            if (rsp_tdata[63:0] !== want.fx) begin
               $display("%0t: force_x expected %h actual %h", $time, want.fx, rsp_tdata[63:0]);
               fail_count++;
            end
            if (rsp_tdata[127:64] !== want.fy) begin
               $display("%0t: force_y expected %h actual %h", $time, want.fy,
                        rsp_tdata[127:64]);
               fail_count++;
            end
            if (rsp_tuser !== want.st) begin
               $display("%0t: status expected %0d actual %0d", $time, want.st, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // Stimulus.
   initial begin
      row_type   rows[$];
      row_type   r;
      force_type none;
      logic [CfgW-1:0] cfg_set[5][2];

      fail_count = 0;
      pairs_taken = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_GRAVITY;
      csr_wdata = '0;
      grav_now = 32'd65536;
      soft_now = 32'd1;
      none = '{fx: '0, fy: '0, st: STAT_OK};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows; typed answers where they are obvious.
      r.typed = 1'b1;
      r.want = none;
      r.g = 32'd65536; r.eps = 32'd1;
      r.p = '{ax: 0, ay: 0, am: 0, bx: 0, by: 0, bm: 0}; rows.push_back(r);
      r.p = '{ax: 32'h0001_0000, ay: 32'hffff_0000, am: 32'hffff_ffff,
              bx: 32'h0001_0000, by: 32'hffff_0000, bm: 32'hffff_ffff}; rows.push_back(r);
      r.p = '{ax: 0, ay: 0, am: 0, bx: 32'h0003_0000, by: 32'h0004_0000, bm: 32'h0001_0000};
      rows.push_back(r);
      r.g = 32'd0;
      r.p = '{ax: 0, ay: 0, am: 32'h0001_0000, bx: 32'h0003_0000, by: 32'h0004_0000,
              bm: 32'h0001_0000}; rows.push_back(r);
      // Zero distance without softening.
      r.g = 32'd65536; r.eps = 32'd0;
      r.want = '{fx: '0, fy: '0, st: STAT_ZERO};
      r.p = '{ax: 32'h8000_0000, ay: 32'h7fff_ffff, am: 32'hffff_ffff,
              bx: 32'h8000_0000, by: 32'h7fff_ffff, bm: 32'hffff_ffff}; rows.push_back(r);
      r.typed = 1'b0;
      r.p = '{ax: 0, ay: 0, am: 32'h0001_0000, bx: 32'h0003_0000, by: 32'h0004_0000,
              bm: 32'h0001_0000}; rows.push_back(r);
      r.p = '{ax: 0, ay: 0, am: 32'hffff_ffff, bx: 1, by: 0, bm: 32'hffff_ffff};
      rows.push_back(r);
      r.g = 32'hffff_ffff; r.eps = 32'hffff_ffff;
      r.p = '{ax: 32'h8000_0000, ay: 32'h7fff_ffff, am: 32'hffff_ffff,
              bx: 32'h7fff_ffff, by: 32'h8000_0000, bm: 32'hffff_ffff}; rows.push_back(r);
      r.p = '{ax: 32'h7fff_ffff, ay: 32'h8000_0000, am: 32'h0001_0000,
              bx: 32'h8000_0000, by: 32'h7fff_ffff, bm: 32'h0001_0000}; rows.push_back(r);
      r.eps = 32'd1;
      r.p = '{ax: 0, ay: 0, am: 32'hffff_ffff, bx: 32'hffff_ffff, by: 1,
              bm: 32'hffff_ffff}; rows.push_back(r);
      r.g = 32'd65536;
      r.p = '{ax: 32'h0010_0000, ay: 32'hfff0_0000, am: 32'h0002_0000,
              bx: 32'hfff0_0000, by: 32'h0010_0000, bm: 32'h0005_0000}; rows.push_back(r);

      foreach (rows[i]) begin
         set_config(rows[i].g, rows[i].eps);
         send_pair(rows[i].p, rows[i].typed, rows[i].want);
      end

      // Random phases over several register settings.
      cfg_set[0] = '{32'd65536, 32'd1};
      cfg_set[1] = '{32'hffff_ffff, 32'd0};
      cfg_set[2] = '{32'd0, 32'hffff_ffff};
      cfg_set[3] = '{$urandom, $urandom};
      cfg_set[4] = '{$urandom_range(1, 32'h0010_0000), $urandom_range(0, 32'h0001_0000)};
      for (int ph = 0; ph < 5; ph++) begin
         set_config(cfg_set[ph][0], cfg_set[ph][1]);
         for (int n = 0; n < NumRandom / 5; n++) send_pair(random_pair(), 1'b0, none);
      end

      wait (force_queue.size() == 0);
      repeat (Latency + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("[pairwise_gravity_force] OK");
      end else begin
         $display("[pairwise_gravity_force] ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/pgf_pkg.sv
rtl/pairwise_gravity_force.sv
tb/tb.sv
